[rtl/ipsd_pkg.sv]
// Shared types, constants and codes for the icon pixel store downscale unit.
package ipsd_pkg;

    localparam int MAX_PIXELS_DEF      = 65536;
    localparam int MAX_TARGET_SIDE_DEF = 64;
    localparam int ADDR_MAX_W          = 20;
    localparam int DIV_W               = 24;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_SIDE   = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_WRITE = 2'd1,
        OP_EMIT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_EMIT  = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_BAD_ROW   = 2'd2
    } status_t;

    // effective configuration (zero sizes already forced to one)
    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  max_side;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [15:0]             data;
    } cmd_t;

endpackage

[rtl/icon_pixel_store_nearest_downscale_unit.sv]
// Top level: configuration registers, front end, command queue and back end.
//
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       tuser op, tdata col,row,red,green,blue
//  m_*       out        m_tvalid / m_tready       tdata pixel,out_col,dst w/h,status; tlast
//  cfg_*     in         cfg_wen (no wait)         cfg_index, cfg_data
//
// A pixel write keeps the back end in its idle state; the front end takes an item per cycle unless the queue is full.
// An emit does one store read and one output load per target column;
// its row start runs the 24-step divider.
// A clear sweeps every address of the store. After reset the target size is computed
// and the store is cleared; s_tready stays low until the sweep ends.
// Every configuration write repeats the target size computation before the next command.
// A stalled m_tready holds the back end; the queue keeps the front end accepting until it fills.
module icon_pixel_store_nearest_downscale_unit
    import ipsd_pkg::*;
#(
    parameter int MAX_PIXELS      = MAX_PIXELS_DEF,
    parameter int MAX_TARGET_SIDE = MAX_TARGET_SIDE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // col[15:0], row[31:16], red[39:32], green[47:40], blue[55:48]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel[15:0], out_col[23:16], dst_width[31:24],
                                   // dst_height[39:32], status[41:40], zero[47:42]
    output logic        m_tlast,   // last
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] src_width_reg, src_width_next;
    logic [15:0] src_height_reg, src_height_next;
    logic [7:0]  max_side_reg, max_side_next;
    cfg_t        cfg;
    logic        init_busy;
    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_full;
    logic        q_pop;
    cmd_t        q_pop_cmd;
    logic        q_empty;
    logic [15:0] out_pixel;
    logic [7:0]  out_col;
    logic [7:0]  dst_width;
    logic [7:0]  dst_height;
    status_t     out_status;

    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        max_side_next   = max_side_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_next  = cfg_data;
                CFG_SRC_HEIGHT: src_height_next = cfg_data;
                CFG_MAX_SIDE:   max_side_next   = cfg_data[7:0];
                default:        max_side_next   = max_side_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 16'd64;
            src_height_reg <= 16'd64;
            max_side_reg   <= 8'd64;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            max_side_reg   <= max_side_next;
        end
    end

    // a zero size acts as one
    assign cfg.w        = (src_width_reg == 16'd0) ? 16'd1 : src_width_reg;
    assign cfg.h        = (src_height_reg == 16'd0) ? 16'd1 : src_height_reg;
    assign cfg.max_side = max_side_reg;

    ipsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .hold     (init_busy),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_col   (s_tdata[15:0]),
        .in_row   (s_tdata[31:16]),
        .in_red   (s_tdata[39:32]),
        .in_green (s_tdata[47:40]),
        .in_blue  (s_tdata[55:48]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    ipsd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    ipsd_back #(
        .MAX_PIXELS      (MAX_PIXELS),
        .MAX_TARGET_SIDE (MAX_TARGET_SIDE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_written (cfg_wen),
        .q_empty     (q_empty),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (out_pixel),
        .out_col     (out_col),
        .dst_width   (dst_width),
        .dst_height  (dst_height),
        .out_status  (out_status),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, out_status, dst_height, dst_width, out_col, out_pixel};

    // error results are single items at column zero
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != ST_OK) |-> m_tlast && (out_col == 8'd0))
        else $error("error result not a single item");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_col < dst_width)
        else $error("target column beyond target width");

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && (out_status == ST_OK) |-> out_col == dst_width - 8'd1)
        else $error("row ended before its last column");

    a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !(s_tvalid && s_tready) && !m_tvalid)
        else $error("item moved during store clearing after reset");

endmodule

[rtl/ipsd_div.sv]
// Restoring divider, one quotient bit per cycle.
module ipsd_div
    import ipsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [15:0]      divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [15:0]      remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 16'd0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[15:0] : trial[15:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/ipsd_front.sv]
// Front end: accepts items, drops invalid ones, packs pixels and forms store addresses.
module ipsd_front
    import ipsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        hold,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_op,
    input  logic [15:0] in_col,
    input  logic [15:0] in_row,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic        stg_valid_reg, stg_valid_next;
    logic        stg_keep_reg, stg_keep_next;
    cmd_kind_t   stg_kind_reg, stg_kind_next;
    logic [31:0] stg_prod_reg, stg_prod_next;
    logic [15:0] stg_col_reg, stg_col_next;
    logic [15:0] stg_data_reg, stg_data_next;
    logic        accept;
    logic        advance;
    logic [31:0] addr_sum;

    // RGB565 with its two bytes swapped
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [15:0] c;
        c = {r[7:3], g[7:2], b[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

    assign advance  = !stg_keep_reg || !q_full;
    assign in_ready = !hold && (!stg_valid_reg || advance);
    assign accept   = in_valid && in_ready;
    assign addr_sum = stg_prod_reg + {16'd0, stg_col_reg};

    assign q_push    = stg_valid_reg && stg_keep_reg && !q_full;
    assign q_cmd.kind = stg_kind_reg;
    assign q_cmd.addr = addr_sum[ADDR_MAX_W-1:0];
    assign q_cmd.data = stg_data_reg;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_keep_next  = stg_keep_reg;
        stg_kind_next  = stg_kind_reg;
        stg_prod_next  = stg_prod_reg;
        stg_col_next   = stg_col_reg;
        stg_data_next  = stg_data_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
            stg_prod_next  = in_row * cfg.w;
            stg_col_next   = in_col;
            case (in_op)
                OP_CLEAR:
                begin
                    stg_keep_next = 1'b1;
                    stg_kind_next = CMD_CLEAR;
                    stg_data_next = 16'd0;
                end
                OP_WRITE:
                begin
                    stg_keep_next = (in_col < cfg.w) && (in_row < cfg.h);
                    stg_kind_next = CMD_WRITE;
                    stg_data_next = pack565(in_red, in_green, in_blue);
                end
                OP_EMIT:
                begin
                    stg_keep_next = 1'b1;
                    stg_kind_next = CMD_EMIT;
                    stg_data_next = in_row;
                end
                default:
                begin
                    stg_keep_next = 1'b0;
                    stg_kind_next = CMD_CLEAR;
                    stg_data_next = 16'd0;
                end
            endcase
        end
        else if (stg_valid_reg && advance)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            stg_keep_reg  <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            stg_keep_reg  <= stg_keep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_kind_reg <= stg_kind_next;
        stg_prod_reg <= stg_prod_next;
        stg_col_reg  <= stg_col_next;
        stg_data_reg <= stg_data_next;
    end

endmodule

[rtl/ipsd_fifo.sv]
// Short command queue between front end and back end.
module ipsd_fifo
    import ipsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = count_reg == CW'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/ipsd_back.sv]
// Back end: target size setup, frame store, clear sweep and row emission.
module ipsd_back
    import ipsd_pkg::*;
#(
    parameter int MAX_PIXELS      = MAX_PIXELS_DEF,
    parameter int MAX_TARGET_SIDE = MAX_TARGET_SIDE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cfg_written,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        init_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_pixel,
    output logic [7:0]  out_col,
    output logic [7:0]  dst_width,
    output logic [7:0]  dst_height,
    output status_t     out_status,
    output logic        out_last
);

    localparam int AW = $clog2(MAX_PIXELS);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_CLEAR     = 15'b000000000000010,
        S_SET_MUL   = 15'b000000000000100,
        S_SET_MINOR = 15'b000000000001000,
        S_SET_DIV1  = 15'b000000000010000,
        S_SET_WAIT1 = 15'b000000000100000,
        S_SET_DIV2  = 15'b000000001000000,
        S_SET_WAIT2 = 15'b000000010000000,
        S_EMIT_MUL  = 15'b000000100000000,
        S_EMIT_DIV  = 15'b000001000000000,
        S_EMIT_WAIT = 15'b000010000000000,
        S_EMIT_BASE = 15'b000100000000000,
        S_EMIT_RD   = 15'b001000000000000,
        S_EMIT_OUT  = 15'b010000000000000,
        S_RESULT    = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic             setup_pend_reg, setup_pend_next;
    logic             clear_pend_reg, clear_pend_next;
    logic             init_reg, init_next;
    logic             too_large_reg, too_large_next;
    logic [7:0]       side_reg, side_next;
    logic [7:0]       dw_reg, dw_next;
    logic [7:0]       dh_reg, dh_next;
    logic [15:0]      qw_reg, qw_next;
    logic [7:0]       rw_reg, rw_next;
    logic [31:0]      wh_reg, wh_next;
    logic [DIV_W-1:0] mul_reg, mul_next;
    logic [7:0]       row_reg, row_next;
    logic [15:0]      sy_reg, sy_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [7:0]       x_reg, x_next;
    logic [15:0]      sxq_reg, sxq_next;
    logic [7:0]       sxr_reg, sxr_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    status_t          res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_pixel_reg, out_pixel_next;
    logic [7:0]       out_col_reg, out_col_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;
    logic [15:0]      rd_data_reg;

    logic [15:0]      store [MAX_PIXELS];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [15:0]      div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [15:0]      div_rem;

    logic             w_ge_h;
    logic [15:0]      major;
    logic [15:0]      minor;
    logic [7:0]       lim_raw;
    logic [7:0]       lim;
    logic [7:0]       minor_res;
    logic [8:0]       r_sum;
    logic             r_wrap;
    logic             out_free;
    logic             is_last;

    ipsd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign w_ge_h    = cfg.w >= cfg.h;
    assign major     = w_ge_h ? cfg.w : cfg.h;
    assign minor     = w_ge_h ? cfg.h : cfg.w;
    assign lim_raw   = (cfg.max_side < 8'(MAX_TARGET_SIDE)) ? cfg.max_side
                                                            : 8'(MAX_TARGET_SIDE);
    assign lim       = (lim_raw == 8'd0) ? 8'd1 : lim_raw;
    assign minor_res = (div_quo == '0) ? 8'd1 : div_quo[7:0];

    // incremental sx = x*w/dw: quotient and remainder step by w/dw and w%dw
    assign r_sum  = {1'b0, sxr_reg} + {1'b0, rw_reg};
    assign r_wrap = r_sum >= {1'b0, dw_reg};

    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = x_reg == (dw_reg - 8'd1);

    assign q_pop = (state_reg == S_IDLE) && !setup_pend_reg && !clear_pend_reg && !q_empty;

    assign mem_we    = (state_reg == S_CLEAR) ||
                       (q_pop && (q_cmd.kind == CMD_WRITE) && !too_large_reg);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : q_cmd.addr[AW-1:0];
    assign mem_wdata = (state_reg == S_CLEAR) ? 16'd0 : q_cmd.data;
    assign mem_re    = state_reg == S_EMIT_RD;
    assign mem_raddr = base_reg + AW'(sxq_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = mul_reg;
        div_divisor  = major;
        case (state_reg)
            S_SET_DIV1:
            begin
                div_start = 1'b1;
            end
            S_SET_DIV2:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(cfg.w);
                div_divisor  = {8'd0, dw_reg};
            end
            S_EMIT_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = {8'd0, dh_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        setup_pend_next = setup_pend_reg || cfg_written;
        clear_pend_next = clear_pend_reg;
        init_next       = init_reg;
        too_large_next  = too_large_reg;
        side_next       = side_reg;
        dw_next         = dw_reg;
        dh_next         = dh_reg;
        qw_next         = qw_reg;
        rw_next         = rw_reg;
        wh_next         = wh_reg;
        mul_next        = mul_reg;
        row_next        = row_reg;
        sy_next         = sy_reg;
        base_next       = base_reg;
        x_next          = x_reg;
        sxq_next        = sxq_reg;
        sxr_next        = sxr_reg;
        clr_addr_next   = clr_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_pixel_next  = out_pixel_reg;
        out_col_next    = out_col_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (setup_pend_reg)
                begin
                    setup_pend_next = cfg_written;
                    state_next      = S_SET_MUL;
                end
                else if (clear_pend_reg)
                begin
                    clear_pend_next = 1'b0;
                    clr_addr_next   = '0;
                    state_next      = S_CLEAR;
                end
                else if (q_pop)
                begin
                    case (q_cmd.kind)
                        CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        CMD_EMIT:
                        begin
                            row_next = q_cmd.data[7:0];
                            if (too_large_reg)
                            begin
                                res_status_next = ST_TOO_LARGE;
                                state_next      = S_RESULT;
                            end
                            else if (q_cmd.data >= {8'd0, dh_reg})
                            begin
                                res_status_next = ST_BAD_ROW;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_EMIT_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_PIXELS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_SET_MUL:
            begin
                wh_next    = cfg.w * cfg.h;
                side_next  = (major <= {8'd0, lim}) ? major[7:0] : lim;
                state_next = S_SET_MINOR;
            end
            S_SET_MINOR:
            begin
                too_large_next = wh_reg > 32'(MAX_PIXELS);
                mul_next       = minor * side_reg;
                state_next     = S_SET_DIV1;
            end
            S_SET_DIV1:
            begin
                state_next = S_SET_WAIT1;
            end
            S_SET_WAIT1:
            begin
                if (div_done)
                begin
                    dw_next    = w_ge_h ? side_reg : minor_res;
                    dh_next    = w_ge_h ? minor_res : side_reg;
                    state_next = S_SET_DIV2;
                end
            end
            S_SET_DIV2:
            begin
                state_next = S_SET_WAIT2;
            end
            S_SET_WAIT2:
            begin
                if (div_done)
                begin
                    qw_next    = div_quo[15:0];
                    rw_next    = div_rem[7:0];
                    state_next = S_IDLE;
                end
            end
            S_EMIT_MUL:
            begin
                mul_next   = row_reg * cfg.h;
                state_next = S_EMIT_DIV;
            end
            S_EMIT_DIV:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (div_done)
                begin
                    sy_next    = div_quo[15:0];
                    state_next = S_EMIT_BASE;
                end
            end
            S_EMIT_BASE:
            begin
                base_next  = AW'(sy_reg * cfg.w);
                x_next     = 8'd0;
                sxq_next   = 16'd0;
                sxr_next   = 8'd0;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pixel_next  = rd_data_reg;
                    out_col_next    = x_reg;
                    out_status_next = ST_OK;
                    out_last_next   = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        x_next     = x_reg + 8'd1;
                        sxr_next   = r_wrap ? 8'(r_sum - {1'b0, dw_reg}) : r_sum[7:0];
                        sxq_next   = sxq_reg + qw_reg + (r_wrap ? 16'd1 : 16'd0);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pixel_next  = 16'd0;
                    out_col_next    = 8'd0;
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            setup_pend_reg <= 1'b1;
            clear_pend_reg <= 1'b1;
            init_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            setup_pend_reg <= setup_pend_next;
            clear_pend_reg <= clear_pend_next;
            init_reg       <= init_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        too_large_reg  <= too_large_next;
        side_reg       <= side_next;
        dw_reg         <= dw_next;
        dh_reg         <= dh_next;
        qw_reg         <= qw_next;
        rw_reg         <= rw_next;
        wh_reg         <= wh_next;
        mul_reg        <= mul_next;
        row_reg        <= row_next;
        sy_reg         <= sy_next;
        base_reg       <= base_next;
        x_reg          <= x_next;
        sxq_reg        <= sxq_next;
        sxr_reg        <= sxr_next;
        clr_addr_reg   <= clr_addr_next;
        res_status_reg <= res_status_next;
        out_pixel_reg  <= out_pixel_next;
        out_col_reg    <= out_col_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= store[mem_raddr];
    end

    assign init_busy  = init_reg;
    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_col    = out_col_reg;
    assign dst_width  = dw_reg;
    assign dst_height = dh_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

[dv/tb_icon_pixel_store_nearest_downscale_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the icon pixel store nearest-neighbour downscale unit.
module tb_icon_pixel_store_nearest_downscale_unit;
    import ipsd_pkg::*;

    localparam int         STORE_DEPTH   = MAX_PIXELS_DEF;
    localparam int         SIDE_LIMIT    = MAX_TARGET_SIDE_DEF;
    localparam int         SETTLE_CYCLES = 400;
    localparam int         LONG_HOLD     = 3000;
    localparam int         PHASE_ITEMS   = 48;
    localparam int         RAND_PHASES   = 6;
    localparam longint     CYCLE_LIMIT   = 20000000;
    localparam logic [1:0] OP_UNDEF      = 2'd3;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    typedef struct {
        logic [15:0] pixel;
        logic [7:0]  out_col;
        logic [7:0]  dst_w;
        logic [7:0]  dst_h;
        status_t     status;
        logic        last;
    } row_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // col[15:0], row[31:16], red[39:32], green[47:40], blue[55:48]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // pixel[15:0], out_col[23:16], dst_width[31:24],
                            // dst_height[39:32], status[41:40]
    logic        m_tlast;   // last
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    icon_pixel_store_nearest_downscale_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the store and the registers
    logic [15:0] frame_mem [STORE_DEPTH];
    logic [15:0] cur_w;
    logic [15:0] cur_h;
    logic [7:0]  cur_side;
    row_pixel_t  pending_pixels [$];

    int     mismatch_count = 0;
    int     clears_left    = 2;
    bit     steady         = 1'b0;
    bit     hold_long      = 1'b0;
    longint cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned src_w_eff();
        return (cur_w == 16'd0) ? 1 : cur_w;
    endfunction

    function automatic int unsigned src_h_eff();
        return (cur_h == 16'd0) ? 1 : cur_h;
    endfunction

    function automatic bit oversized();
        longint unsigned area;
        area = longint'(src_w_eff()) * longint'(src_h_eff());
        return area > STORE_DEPTH;
    endfunction

    function automatic void target_dims(output logic [7:0] dw, output logic [7:0] dh);
        int unsigned w;
        int unsigned h;
        int unsigned lim;
        int unsigned tw;
        int unsigned th;
        w   = src_w_eff();
        h   = src_h_eff();
        lim = (cur_side < SIDE_LIMIT) ? cur_side : SIDE_LIMIT;
        if (lim == 0)
            lim = 1;
        if (w >= h)
        begin
            tw = (w <= lim) ? w : lim;
            th = (h * tw) / w;
        end
        else
        begin
            th = (h <= lim) ? h : lim;
            tw = (w * th) / h;
        end
        if (tw == 0)
            tw = 1;
        if (th == 0)
            th = 1;
        dw = tw[7:0];
        dh = th[7:0];
    endfunction

    // Updates the store copy and queues the pixels an emit will return.
    function automatic void predict_item(input logic [1:0] op, input logic [15:0] col,
                                         input logic [15:0] row, input logic [7:0] red,
                                         input logic [7:0] green, input logic [7:0] blue);
        int unsigned w;
        int unsigned h;
        int unsigned sy;
        int unsigned sx;
        int unsigned x;
        logic [7:0]  dw;
        logic [7:0]  dh;
        logic [15:0] c;
        row_pixel_t  e;
        w = src_w_eff();
        h = src_h_eff();
        case (op)
            OP_CLEAR:
                foreach (frame_mem[i])
                    frame_mem[i] = 16'd0;
            OP_WRITE:
                if (!oversized() && col < w && row < h)
                begin
                    c = {red[7:3], green[7:2], blue[7:3]};
                    frame_mem[row * w + col] = {c[7:0], c[15:8]};
                end
            OP_EMIT:
            begin
                target_dims(dw, dh);
                e.dst_w = dw;
                e.dst_h = dh;
                if (oversized() || row >= dh)
                begin
                    e.pixel   = 16'd0;
                    e.out_col = 8'd0;
                    e.status  = oversized() ? ST_TOO_LARGE : ST_BAD_ROW;
                    e.last    = 1'b1;
                    pending_pixels.push_back(e);
                end
                else
                begin
                    sy = (row * h) / dh;
                    for (x = 0; x < dw; x++)
                    begin
                        sx        = (x * w) / dw;
                        e.pixel   = frame_mem[sy * w + sx];
                        e.out_col = x[7:0];
                        e.status  = ST_OK;
                        e.last    = (x + 1 == dw);
                        pending_pixels.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] col,
                             input logic [15:0] row, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {blue, green, red, row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(op, col, row, red, green, blue);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SRC_WIDTH:  cur_w    = data;
            CFG_SRC_HEIGHT: cur_h    = data;
            CFG_MAX_SIDE:   cur_side = data[7:0];
            default: ;
        endcase
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // every phase ends in an emit, so once its pixels are back only short work remains
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] side);
        settle();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_MAX_SIDE, {8'd0, side});
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        row_pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel", want.pixel, m_tdata[15:0]);
                check_field("out_col", 16'(want.out_col), 16'(m_tdata[23:16]));
                check_field("dst_width", 16'(want.dst_w), 16'(m_tdata[31:24]));
                check_field("dst_height", 16'(want.dst_h), 16'(m_tdata[39:32]));
                check_field("status", 16'(want.status), 16'(m_tdata[41:40]));
                check_field("last", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic test_reset_defaults();
        // store is swept clean after reset; 64x64 source gives a 64x64 target
        send_item(OP_EMIT, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_WRITE, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_WRITE, 16'd63, 16'd63, 8'hFF, 8'h00, 8'h00);
        send_item(OP_WRITE, 16'd63, 16'd0, 8'h00, 8'hFF, 8'h00);
        send_item(OP_WRITE, 16'd0, 16'd63, 8'h00, 8'h00, 8'hFF);
        // writes outside the source and undefined ops are dropped
        send_item(OP_WRITE, 16'd64, 16'd0, 8'h12, 8'h34, 8'h56);
        send_item(OP_WRITE, 16'hFFFF, 16'hFFFF, 8'hAA, 8'h55, 8'hAA);
        send_item(OP_WRITE, 16'd5, 16'd64, 8'h87, 8'h65, 8'h43);
        send_item(OP_UNDEF, 16'hFFFF, 16'd0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_EMIT, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_EMIT, 16'd0, 16'd63, 8'd0, 8'd0, 8'd0);
        send_item(OP_EMIT, 16'd0, 16'd64, 8'd0, 8'd0, 8'd0);
        send_item(OP_EMIT, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_EMIT, 16'd0, 16'd63, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_degenerate_sizes();
        // zero sizes act as one
        set_size(16'd0, 16'd0, 8'd64);
        send_item(OP_WRITE, 16'd0, 16'd0, 8'h5A, 8'hA5, 8'h3C);
        send_item(OP_WRITE, 16'd1, 16'd0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_EMIT, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_EMIT, 16'd0, 16'd1, 8'd0, 8'd0, 8'd0);
        // side limit of zero acts as one, zero height rounds up
        set_size(16'd5, 16'd3, 8'd0);
        send_item(OP_EMIT, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        // side limit above the build limit is clipped
        set_size(16'd200, 16'd100, 8'd255);
        send_item(OP_WRITE, 16'd196, 16'd96, 8'hC3, 8'h3C, 8'h81);
        send_item(OP_EMIT, 16'd0, 16'd31, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_oversized_source();
        // exactly the store size still fits
        set_size(16'd256, 16'd256, 8'd64);
        send_item(OP_WRITE, 16'd252, 16'd252, 8'h9F, 8'h60, 8'h0F);
        send_item(OP_EMIT, 16'd0, 16'd63, 8'd0, 8'd0, 8'd0);
        set_size(16'd257, 16'd256, 8'd64);
        send_item(OP_WRITE, 16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_EMIT, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        set_size(16'hFFFF, 16'hFFFF, 8'd255);
        send_item(OP_EMIT, 16'd0, 16'd300, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_tall_aspect();
        set_size(16'd10, 16'd40, 8'd16);
        send_item(OP_EMIT, 16'd0, 16'd15, 8'd0, 8'd0, 8'd0);
        // narrow source: target width rounds down to zero, forced to one
        set_size(16'd3, 16'd200, 8'd64);
        send_item(OP_WRITE, 16'd0, 16'd196, 8'h78, 8'h9A, 8'hBC);
        send_item(OP_EMIT, 16'd0, 16'd63, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_backpressure();
        int k;
        set_size(16'd64, 16'd64, 8'd64);
        steady    = 1'b1;
        hold_long = 1'b1;
        // queue and output fill while the receiver holds off; s_tready must drop
        for (k = 0; k < 8; k++)
            send_item(OP_EMIT, 16'd0, 16'($urandom_range(0, 63)), 8'd0, 8'd0, 8'd0);
        // sender pauses until the block has drained
        wait_results();
        steady = 1'b0;
        for (k = 0; k < 3; k++)
            send_item(OP_WRITE, 16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
                      8'($urandom()), 8'($urandom()), 8'($urandom()));
        send_item(OP_EMIT, 16'd0, 16'($urandom_range(0, 63)), 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        int          sel;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  side;
        logic [7:0]  dw;
        logic [7:0]  dh;
        settle();
        // index with no register behind it
        write_reg(CFG_UNUSED, 16'($urandom()));
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase == 3)
            begin
                w = 16'($urandom_range(257, 65535));
                h = 16'($urandom_range(257, 65535));
            end
            else
            begin
                w = 16'($urandom_range(0, 80));
                h = 16'($urandom_range(0, 80));
            end
            side = (phase % 2 == 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 64));
            set_size(w, h, side);
            steady = (phase == 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = (n == PHASE_ITEMS - 1) ? 90 : $urandom_range(0, 99);
                target_dims(dw, dh);
                if (sel < 55)
                    send_item(OP_WRITE, 16'($urandom_range(0, src_w_eff() - 1)),
                              16'($urandom_range(0, src_h_eff() - 1)),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                else if (sel < 63)
                    send_item(OP_WRITE, 16'($urandom()), 16'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                else if (sel < 66)
                    send_item(OP_UNDEF, 16'($urandom()), 16'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                else if (sel < 67 && clears_left > 0)
                begin
                    clears_left--;
                    send_item(OP_CLEAR, 16'($urandom()), 16'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                end
                else if (sel < 94)
                    send_item(OP_EMIT, 16'($urandom()), 16'($urandom_range(0, dh - 1)),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
                else
                    send_item(OP_EMIT, 16'($urandom()), 16'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= 56'd0;
        s_tuser   <= OP_CLEAR;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= 16'd0;
        rst_n     <= 1'b0;
        cur_w      = 16'd64;
        cur_h      = 16'd64;
        cur_side   = 8'd64;
        foreach (frame_mem[i])
            frame_mem[i] = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_degenerate_sizes();
        test_oversized_source();
        test_tall_aspect();
        test_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/ipsd_pkg.sv
rtl/ipsd_div.sv
rtl/ipsd_front.sv
rtl/ipsd_fifo.sv
rtl/ipsd_back.sv
rtl/icon_pixel_store_nearest_downscale_unit.sv
dv/tb_icon_pixel_store_nearest_downscale_unit.sv
